@@ rtl/nmp_pkg.sv @@
// Package for the note name parser: phase codes, character codes and the letter-to-semitone map.
`default_nettype none

package nmp_pkg;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_LETTER = 3'd1,
      PH_FLAT   = 3'd2,
      PH_ACC    = 3'd3,
      PH_MINUS  = 3'd4,
      PH_DIGITS = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_DELTA = 8'd32;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_E       = 8'h45;
   localparam logic [7:0] CH_F       = 8'h46;
   localparam logic [7:0] CH_G       = 8'h47;
   localparam logic [7:0] CH_Z       = 8'h5a;
   localparam logic [7:0] CH_SHARP   = 8'h23;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [6:0] OCTAVE_MAX = 7'd99;
   localparam logic [6:0] OCTAVE_TOP_DIGIT = 7'd9;

   // Semitone of a note letter within its octave; B is the fallthrough.
   function automatic logic signed [4:0] base_semitone(input logic [7:0] ch);
      logic signed [4:0] s;
      begin
         unique case (ch)
            CH_C:    s = 5'sd0;
            CH_D:    s = 5'sd2;
            CH_E:    s = 5'sd4;
            CH_F:    s = 5'sd5;
            CH_G:    s = 5'sd7;
            CH_A:    s = 5'sd9;
            default: s = 5'sd11;
         endcase
         return s;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/note_name_to_midi_parser.sv @@
// Top level of the note name parser: streams name characters in, emits one MIDI number per name.
`default_nettype none

// Usage
// The req channel carries one character of a note name per word; req_tlast marks the
// final character. Lower-case letters are folded to upper case. The parser finds the
// first note letter A-G not preceded by a letter, an optional sharp or flat, an optional
// minus and the octave digits (saturating at 99). For each name exactly one word leaves
// on the rsp channel, on its last character: rsp_tuser is the found flag and
// rsp_tdata holds the MIDI number (C-1 is 0, A4 is 69), or zero when nothing was found.
// Timing: every accepted character is registered, then the parse state is updated by
// combinational logic, and the result word is registered. rsp_tvalid rises when the last
// character passes from the input register into the result register. One character is
// taken per cycle while no last character waits on the result register, since the
// whole per-character update is a single pass through the decode logic between the
// input register and the state and result registers.
// When the receiver stalls, a last character waits in the input register until the
// result register frees; other characters keep flowing, so at most one pending name
// result blocks the input. Reset returns the parser to the search state with no
// pending input or result words.
module note_name_to_midi_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic        req_tlast,   // last character of the name
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [11:0] note_number (signed), [15:12] zero
   output logic             rsp_tuser    // [0] found
);
   import nmp_pkg::*;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        in_last_ff;

   // Parse state.
   phase_type          phase_ff, phase_in;
   logic               prior_ff, prior_in;
   logic signed [4:0]  semi_ff, semi_in;
   logic               neg_ff, neg_in;
   logic [6:0]         oct_ff, oct_in;
   logic               match_ff, match_in;
   logic signed [11:0] held_ff, held_in;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic               out_found_ff;
   logic signed [11:0] out_number_ff;

   logic fire;
   logic out_free;

   // A last character needs the result register; other words always advance.
   assign out_free    = !out_valid_ff || rsp_tready;
   assign fire        = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);
   assign out_valid_in = (fire && in_last_ff) || (out_valid_ff && !rsp_tready);

   // Per-character decode.
   logic [7:0]        ch;
   logic              ch_letter, ch_digit, ch_note;
   logic [3:0]        digit;
   logic [6:0]        oct_take;
   logic              take, ok;
   logic signed [7:0] oct_signed, oct_plus;
   logic signed [11:0] held_calc;

   always_comb begin
      ch = in_char_ff;
      if (in_char_ff >= CH_LOWER_A && in_char_ff <= CH_LOWER_Z) begin
         ch = in_char_ff - CASE_DELTA;
      end
      ch_letter = (ch >= CH_A) && (ch <= CH_Z);
      ch_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
      ch_note   = (ch >= CH_A) && (ch <= CH_G);
      digit     = 4'(ch - CH_ZERO);

      // Octave saturates once a third digit would push past 99.
      if (oct_ff > OCTAVE_TOP_DIGIT) begin
         oct_take = OCTAVE_MAX;
      end else begin
         oct_take = {oct_ff[3:0], 3'b000} + {oct_ff[5:0], 1'b0} + {3'b000, digit};
      end

      phase_in = phase_ff;
      semi_in  = semi_ff;
      neg_in   = neg_ff;
      oct_in   = oct_ff;
      match_in = match_ff;
      held_in  = held_ff;
      take     = 1'b0;
      ok       = 1'b1;

      unique case (phase_ff)
         PH_LETTER: begin
            if (ch == CH_SHARP) begin
               semi_in  = semi_ff + 5'sd1;
               phase_in = PH_ACC;
            end else if (ch == CH_B) begin
               phase_in = PH_FLAT;
            end else if (ch == CH_MINUS) begin
               phase_in = PH_MINUS;
            end else if (ch_digit) begin
               take = 1'b1;
            end else begin
               ok = 1'b0;
            end
         end
         PH_FLAT: begin
            // The B is a flat only if no letter follows it.
            if (ch_letter) begin
               ok = 1'b0;
            end else begin
               semi_in = semi_ff - 5'sd1;
               if (ch == CH_MINUS) begin
                  phase_in = PH_MINUS;
               end else if (ch_digit) begin
                  take = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
         end
         PH_ACC: begin
            if (ch == CH_MINUS) begin
               phase_in = PH_MINUS;
            end else if (ch_digit) begin
               take = 1'b1;
            end else begin
               ok = 1'b0;
            end
         end
         PH_MINUS: begin
            if (ch_digit) begin
               take = 1'b1;
            end else begin
               ok = 1'b0;
            end
         end
         PH_DIGITS: begin
            if (ch_digit) begin
               take = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase

      // MIDI number = (octave + 1) * 12 + semitone, with the times twelve as two shifts.
      oct_signed = neg_ff ? -$signed({1'b0, oct_take}) : $signed({1'b0, oct_take});
      oct_plus   = oct_signed + 8'sd1;
      held_calc  = ($signed({{4{oct_plus[7]}}, oct_plus}) <<< 3)
                 + ($signed({{4{oct_plus[7]}}, oct_plus}) <<< 2)
                 + $signed({{7{semi_in[4]}}, semi_in});

      if (take) begin
         oct_in   = oct_take;
         held_in  = held_calc;
         match_in = 1'b1;
         phase_in = PH_DIGITS;
      end

      // A broken candidate hands its character back to the search.
      if (!ok) begin
         phase_in = PH_SEARCH;
      end
      if (phase_in == PH_SEARCH && ch_note && !prior_ff) begin
         semi_in  = base_semitone(ch);
         neg_in   = 1'b0;
         oct_in   = '0;
         phase_in = PH_LETTER;
      end
      if (phase_in == PH_MINUS && ch == CH_MINUS) begin
         neg_in = 1'b1;
      end
      prior_in = ch_letter;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && in_last_ff)) begin
         phase_ff <= PH_SEARCH;
         prior_ff <= 1'b0;
         semi_ff  <= '0;
         neg_ff   <= 1'b0;
         oct_ff   <= '0;
         match_ff <= 1'b0;
         held_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         prior_ff <= prior_in;
         semi_ff  <= semi_in;
         neg_ff   <= neg_in;
         oct_ff   <= oct_in;
         match_ff <= match_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (fire && in_last_ff) begin
         out_found_ff  <= match_in;
         out_number_ff <= match_in ? held_in : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = {4'b0000, out_number_ff};

`ifndef SYNTHESIS
   a_zero_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("result number not zero for a name without a note");

   a_clear_after_name: assert property (@(posedge clock) disable iff (reset)
      fire && in_last_ff |=> phase_ff == PH_SEARCH && !match_ff)
      else $error("parse state not cleared after the last character");

   a_match_phase: assert property (@(posedge clock) disable iff (reset)
      match_ff |-> phase_ff == PH_DIGITS || phase_ff == PH_DONE)
      else $error("match held outside the octave phases");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_tready |-> in_last_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

@@ test/note_name_to_midi_parser_tb.sv @@
// Self-checking testbench for the note name parser: character streams in, MIDI numbers out.
`default_nettype none

module note_name_to_midi_parser_tb;
   import nmp_pkg::*;

   // Cycles without any handshake on either side before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic        found;
      logic [11:0] number;
   } midi_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   note_name_to_midi_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Results predicted for names whose last character was accepted, oldest first.
   midi_result_type pending_notes[$];
   logic [7:0]      name_buf[$];

   // Bookkeeping for the summary and the verdict.
   int  fail_count    = 0;
   int  chars_sent    = 0;
   int  names_sent    = 0;
   int  results_seen  = 0;
   int  found_seen    = 0;
   int  idle_cycles   = 0;
   int  stall_left    = 0;
   // While set, neither side inserts gaps: back-to-back words on both channels.
   bit  steady        = 1'b0;

   wire req_fire = req_tvalid && req_tready;
   wire rsp_fire = rsp_tvalid && rsp_tready;

   // Appends one character to the name being built.
   function automatic void add_to_name(logic [7:0] c);
      name_buf.insert(name_buf.size(), c);
   endfunction

   // ------------------------------------------------------------------
   // Parser prediction. Mirrors the per-character behavior of the block:
   // a note letter A-G not preceded by a letter opens a candidate, an
   // optional sharp or flat follows, then an optional minus and digits.
   // ------------------------------------------------------------------
   phase_type scan_phase;
   bit        after_letter;
   int        cand_semitone;
   bit        cand_negative;
   int        cand_octave;
   bit        note_matched;
   int        matched_number;

   function automatic void clear_parse();
      scan_phase     = PH_SEARCH;
      after_letter   = 1'b0;
      cand_semitone  = 0;
      cand_negative  = 1'b0;
      cand_octave    = 0;
      note_matched   = 1'b0;
      matched_number = 0;
   endfunction

   function automatic bit is_upper(logic [7:0] c);
      return c >= CH_A && c <= CH_Z;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic int letter_offset(logic [7:0] c);
      if (c == CH_C) return 0;
      if (c == CH_D) return 2;
      if (c == CH_E) return 4;
      if (c == CH_F) return 5;
      if (c == CH_G) return 7;
      if (c == CH_A) return 9;
      return 11;
   endfunction

   // Every digit refreshes the held match, so a name that carries on past
   // the octave still reports the number as it stood after the last digit.
   function automatic void absorb_digit(logic [7:0] c);
      int d;
      int signed_octave;
      d = int'(c) - int'(CH_ZERO);
      if (cand_octave > int'(OCTAVE_TOP_DIGIT)) begin
         cand_octave = int'(OCTAVE_MAX);
      end else begin
         cand_octave = cand_octave * 10 + d;
         if (cand_octave > int'(OCTAVE_MAX)) cand_octave = int'(OCTAVE_MAX);
      end
      signed_octave  = cand_negative ? -cand_octave : cand_octave;
      matched_number = (signed_octave + 1) * 12 + cand_semitone;
      note_matched   = 1'b1;
      scan_phase     = PH_DIGITS;
   endfunction

   function automatic bit start_octave(logic [7:0] c);
      if (c == CH_MINUS) begin
         scan_phase = PH_MINUS;
         return 1'b1;
      end
      if (is_digit(c)) begin
         absorb_digit(c);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Returns 1 when the character closes a name, with the result in res.
   function automatic bit parse_char(logic [7:0] raw, bit last, output midi_result_type res);
      logic [7:0] c;
      bit         ok;
      c   = raw;
      ok  = 1'b1;
      res = '0;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_DELTA;

      case (scan_phase)
         PH_LETTER: begin
            if (c == CH_SHARP) begin
               cand_semitone = cand_semitone + 1;
               scan_phase    = PH_ACC;
            end else if (c == CH_B) begin
               scan_phase = PH_FLAT;
            end else begin
               ok = start_octave(c);
            end
         end
         PH_FLAT: begin
            // The B only becomes a flat when no letter follows it.
            if (is_upper(c)) begin
               ok = 1'b0;
            end else begin
               cand_semitone = cand_semitone - 1;
               ok = start_octave(c);
            end
         end
         PH_ACC:    ok = start_octave(c);
         PH_MINUS: begin
            if (is_digit(c)) absorb_digit(c);
            else ok = 1'b0;
         end
         PH_DIGITS: begin
            if (is_digit(c)) absorb_digit(c);
            else scan_phase = PH_DONE;
         end
         PH_DONE:   ;
         default:   scan_phase = PH_SEARCH;
      endcase
      if (!ok) scan_phase = PH_SEARCH;

      // A broken candidate lets the same character try to open a new one.
      if (scan_phase == PH_SEARCH && c >= CH_A && c <= CH_G && !after_letter) begin
         cand_semitone = letter_offset(c);
         cand_negative = 1'b0;
         cand_octave   = 0;
         scan_phase    = PH_LETTER;
      end
      if (scan_phase == PH_MINUS && c == CH_MINUS) cand_negative = 1'b1;
      after_letter = is_upper(c);

      if (!last) return 1'b0;
      res.found  = note_matched;
      res.number = note_matched ? matched_number[11:0] : 12'd0;
      clear_parse();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Pacing. Most gaps are short, a few run long.
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Receiver back-pressure: random stalls of varied length.
   always @(posedge clock) begin : ready_gen
      int r;
      r = $urandom_range(0, 99);
      if (steady) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (r < 65) begin
         rsp_tready <= 1'b1;
      end else if (r < 92) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else if (r < 98) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(3, 12);
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(25, 60);
      end
   end

   // ------------------------------------------------------------------
   // Result check: every rsp word is matched against the oldest prediction.
   // Handshake signals are sampled at the edge, before any update lands.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      midi_result_type want;
      if (!reset && rsp_fire) begin
         results_seen++;
         if (rsp_tuser) found_seen++;
         if (pending_notes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected result word: found=%0b note=%0d tdata=%h",
                        $time, rsp_tuser, $signed(rsp_tdata[11:0]), rsp_tdata);
         end else begin
            want = pending_notes.pop_front();
            if (rsp_tuser !== want.found || rsp_tdata[11:0] !== want.number ||
                rsp_tdata[15:12] !== 4'b0000) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: mismatch: expected found=%0b note=%0d pad=0, ",
                           $time, want.found, $signed(want.number),
                           "actual found=%0b note=%0d pad=%h",
                           rsp_tuser, $signed(rsp_tdata[11:0]), rsp_tdata[15:12]);
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_notes.size());
            $display("note_name_to_midi_parser_tb NOT OK");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sending. One word per call; the prediction runs at the accepting edge.
   // ------------------------------------------------------------------
   task automatic send_char(logic [7:0] ch, bit last);
      int              gap;
      midi_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      if (last) names_sent++;
      if (parse_char(ch, last, res)) pending_notes.insert(pending_notes.size(), res);
   endtask

   task automatic send_buffer();
      for (int i = 0; i < name_buf.size(); i++)
         send_char(name_buf[i], i == name_buf.size() - 1);
   endtask

   task automatic send_text(string s);
      name_buf.delete();
      for (int i = 0; i < s.len(); i++) add_to_name(s[i]);
      send_buffer();
   endtask

   // The sender holds off until the parser has answered every name so far.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_notes.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Random content.
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'($urandom_range(0, 255));
         3:       return CH_SHARP;
         4:       return CH_MINUS;
         5:       return CH_ZERO + 8'($urandom_range(0, 9));
         6:       return CH_A + 8'($urandom_range(0, 25));
         7:       return CH_LOWER_A + 8'($urandom_range(0, 25));
         8:       return $urandom_range(0, 1) ? CH_B : CH_B + CASE_DELTA;
         default: return 8'h20;
      endcase
   endfunction

   function automatic logic [7:0] pick_note_letter();
      logic [7:0] c;
      c = CH_A + 8'($urandom_range(0, 6));
      if ($urandom_range(0, 1)) c = c + CASE_DELTA;
      return c;
   endfunction

   // Builds a note name such as "x Bb-12q"; when tidy is clear one flaw is added: a
   // stray letter after the accidental, no octave digits, or forced trailing noise.
   task automatic build_name(bit tidy);
      int flaw;
      int n;
      name_buf.delete();
      flaw = tidy ? 0 : $urandom_range(1, 3);
      if ($urandom_range(0, 99) < 30)
         repeat ($urandom_range(1, 3)) add_to_name(pick_noise());
      add_to_name(pick_note_letter());
      case ($urandom_range(0, 9))
         0, 1, 2: add_to_name(CH_SHARP);
         3, 4, 5: add_to_name($urandom_range(0, 1) ? CH_B : CH_B + CASE_DELTA);
         default: ;
      endcase
      if (flaw == 1) add_to_name(CH_A + 8'($urandom_range(0, 25)));
      if ($urandom_range(0, 99) < 30) add_to_name(CH_MINUS);
      if (flaw != 2) begin
         n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 2) : $urandom_range(3, 5);
         repeat (n) add_to_name(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if (flaw == 3 || $urandom_range(0, 99) < 30)
         repeat ($urandom_range(1, 3)) add_to_name(pick_noise());
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Extremes of the number range and every corner of the grammar.
   task automatic test_directed();
      send_text("C#D4");   // broken candidate, D restarts: 62
      send_text("bb-0");   // lower case, flat, negative zero: 22
      send_text("G123");   // octave saturates at 99: 1207
      send_text("CBE");    // B followed by a letter is no flat; ends early
      send_text("zA4");    // A follows a letter: nothing found
      send_text("b#99");   // highest number: 1212
      send_text("cB-99");  // lowest number: -1177
      send_text("F-9Z");   // trailing junk after the octave
      send_text("C-X4");   // minus without a digit breaks the candidate
      send_text("A");      // single letter, no octave
      send_char(8'hff, 1'b1);
      send_char(8'h00, 1'b1);
   endtask

   task automatic test_wellformed_names(int char_target);
      int start;
      start = chars_sent;
      while (chars_sent - start < char_target) begin
         build_name($urandom_range(0, 99) < 85);
         send_buffer();
      end
   endtask

   task automatic test_noise_names(int char_target);
      int start;
      start = chars_sent;
      while (chars_sent - start < char_target) begin
         name_buf.delete();
         repeat ($urandom_range(1, 8)) add_to_name(pick_noise());
         send_buffer();
      end
   endtask

   // Full rate on both channels, one character every cycle.
   task automatic test_back_to_back(int char_target);
      steady = 1'b1;
      test_wellformed_names(char_target);
      steady = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      clear_parse();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_for_results();
      test_wellformed_names(650);
      wait_for_results();
      test_noise_names(300);
      test_back_to_back(150);

      // Let the last result word drain, then allow the pipeline to settle.
      wait_for_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d characters in %0d names: directed corners, well-formed and",
               chars_sent, names_sent);
      $display("damaged names, byte noise and a full-rate stretch; %0d results, %0d found.",
               results_seen, found_seen);
      if (fail_count == 0 && pending_notes.size() == 0) begin
         $display("note_name_to_midi_parser_tb OK");
      end else begin
         $display("note_name_to_midi_parser_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
